// File: design/pal_pkg.sv
// Package for the positional array list: sizes, request and status codes,
// and the command and result structs shared by the control and the cells.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package pal_pkg;

    localparam int DEPTH  = 16;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;

    typedef enum logic [2:0] {
        REQ_INS_FRONT = 3'd0,
        REQ_INS_REAR  = 3'd1,
        REQ_INS_AT    = 3'd2,
        REQ_UPDATE    = 3'd3,
        REQ_RETRIEVE  = 3'd4,
        REQ_DEL_FRONT = 3'd5,
        REQ_DEL_REAR  = 3'd6,
        REQ_DEL_AT    = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic [IDX_W-1:0]          idx;
        logic signed [DATA_W-1:0]  value;
    } cell_cmd_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] count;
        logic             rd_en;
        logic             rd_hit;
        logic [IDX_W-1:0] rd_idx;
    } ctrl_res_t;

endpackage
`default_nettype wire

// File: design/positional_array_list.sv
// Top level of the positional array list: stream ports, the entry count,
// the row of pal_cell instances and the result register. Depends on pal_pkg,
// pal_ctrl and pal_cell.
//
//   channel   direction  tdata                              tuser
//   s_        in         value[31:0], position[39:32]       req_type[2:0]
//   m_        out        read_value[31:0], count[36:32]     status[1:0]
//
// Decode, the parallel shift of the cell row and the read mux all complete
// in the cycle the transfer is accepted.
// The result appears in the output register on the next cycle.
// A stalled result blocks new requests only while it is not taken.
// Reset clears the count and the output valid; cell contents are not reset.
`timescale 1ns / 1ps
`default_nettype none
module positional_array_list import pal_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // value[31:0], position[39:32]
    input  wire logic [2:0]  s_tuser,   // req_type[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // read_value[31:0], entry_count[36:32]
    output logic [1:0]       m_tuser    // status[1:0]
);

    logic                     fire;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    logic signed [DATA_W-1:0] rd_reg;
    logic signed [DATA_W-1:0] rd_next;
    status_t                  status_reg;
    logic [31:0]              count_wide;
    cell_cmd_t                cmd;
    ctrl_res_t                res;

    logic signed [DATA_W-1:0] cell_data [DEPTH];
    logic signed [DATA_W-1:0] left_data [DEPTH];
    logic signed [DATA_W-1:0] right_data [DEPTH];

    assign s_tready = !m_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    pal_ctrl u_ctrl (
        .fire     (fire),
        .req      (req_t'(s_tuser)),
        .value    (s_tdata[31:0]),
        .position (s_tdata[39:32]),
        .count    (count_reg),
        .cmd      (cmd),
        .res      (res)
    );

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign left_data[g] = '0;
        end else begin : g_mid_l
            assign left_data[g] = cell_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign right_data[g] = '0;
        end else begin : g_mid_r
            assign right_data[g] = cell_data[g+1];
        end
        pal_cell u_cell (
            .aclk     (aclk),
            .cell_idx (IDX_W'(g)),
            .cmd      (cmd),
            .left_in  (left_data[g]),
            .right_in (right_data[g]),
            .data_out (cell_data[g])
        );
    end

    always_comb begin
        if (!res.rd_en) begin
            rd_next = '0;
        end else if (res.rd_hit) begin
            rd_next = cell_data[res.rd_idx];
        end else begin
            rd_next = -32'sd1;
        end
        count_next   = fire ? res.count : count_reg;
        m_valid_next = fire ? 1'b1 : (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            rd_reg     <= rd_next;
            status_reg <= res.status;
        end
    end

    assign count_wide = 32'(count_reg);
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = {3'b000, count_wide[4:0], rd_reg};
    assign m_tuser    = status_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= 32'(DEPTH))
        else $error("entry count exceeds list depth");

    a_accept_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid_reg)
        else $error("accepted transfer produced no result");

    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_tready) |-> !s_tready)
        else $error("request accepted while result stalled");

    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && status_reg == ST_FULL) |-> 32'(count_reg) == 32'(DEPTH))
        else $error("full status reported on a list that is not full");
`endif

endmodule
`default_nettype wire

// File: design/pal_cell.sv
// One storage cell of the list: holds one entry and takes data from its
// lower or upper neighbor or from the command value on a broadcast command. Depends on pal_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pal_cell import pal_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic [IDX_W-1:0]          cell_idx,
    input  wire cell_cmd_t                 cmd,
    input  wire logic signed [DATA_W-1:0]  left_in,
    input  wire logic signed [DATA_W-1:0]  right_in,
    output logic signed [DATA_W-1:0]       data_out
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        case (cmd.op)
            CELL_INSERT: begin
                if (cell_idx > cmd.idx) begin
                    data_next = left_in;
                end else if (cell_idx == cmd.idx) begin
                    data_next = cmd.value;
                end
            end
            CELL_DELETE: begin
                if (cell_idx >= cmd.idx) begin
                    data_next = right_in;
                end
            end
            CELL_WRITE: begin
                if (cell_idx == cmd.idx) begin
                    data_next = cmd.value;
                end
            end
            default: begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule
`default_nettype wire

// File: design/pal_ctrl.sv
// Request decoder of the list: checks occupancy and position, forms the
// command broadcast to the cells, the read controls, the status and new count. Depends on pal_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pal_ctrl import pal_pkg::*; (
    input  wire logic                      fire,
    input  wire req_t                      req,
    input  wire logic signed [DATA_W-1:0]  value,
    input  wire logic [7:0]                position,
    input  wire logic [CNT_W-1:0]          count,
    output cell_cmd_t                      cmd,
    output ctrl_res_t                      res
);

    logic             in_range;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] pos_idx;
    logic [IDX_W-1:0] tail_idx;
    logic [CNT_W-1:0] count_inc;
    logic [CNT_W-1:0] count_dec;

    assign in_range  = 32'(position) < 32'(count);
    assign full      = 32'(count) >= 32'(DEPTH);
    assign empty     = count == '0;
    assign pos_idx   = position[IDX_W-1:0];
    assign tail_idx  = count[IDX_W-1:0];
    assign count_inc = CNT_W'(count + 1'b1);
    assign count_dec = CNT_W'(count - 1'b1);

    always_comb begin
        cmd.op     = CELL_HOLD;
        cmd.idx    = '0;
        cmd.value  = value;
        res.status = ST_DONE;
        res.count  = count;
        res.rd_en  = 1'b0;
        res.rd_hit = in_range;
        res.rd_idx = pos_idx;
        case (req)
            REQ_INS_FRONT, REQ_INS_REAR, REQ_INS_AT: begin
                if (full) begin
                    res.status = ST_FULL;
                end else begin
                    cmd.op    = CELL_INSERT;
                    res.count = count_inc;
                    if (req == REQ_INS_FRONT) begin
                        cmd.idx = '0;
                    end else if (req == REQ_INS_AT && in_range) begin
                        cmd.idx = pos_idx;
                    end else begin
                        cmd.idx = tail_idx;
                    end
                end
            end
            REQ_UPDATE: begin
                if (in_range) begin
                    cmd.op  = CELL_WRITE;
                    cmd.idx = pos_idx;
                end else begin
                    res.status = ST_RANGE;
                end
            end
            REQ_RETRIEVE: begin
                res.rd_en = 1'b1;
                if (!in_range) begin
                    res.status = ST_RANGE;
                end
            end
            REQ_DEL_FRONT, REQ_DEL_REAR: begin
                if (empty) begin
                    res.status = ST_RANGE;
                end else begin
                    cmd.op    = CELL_DELETE;
                    cmd.idx   = (req == REQ_DEL_FRONT) ? '0 : count_dec[IDX_W-1:0];
                    res.count = count_dec;
                end
            end
            default: begin
                if (in_range) begin
                    cmd.op    = CELL_DELETE;
                    cmd.idx   = pos_idx;
                    res.count = count_dec;
                end else begin
                    res.status = ST_RANGE;
                end
            end
        endcase
        if (!fire) begin
            cmd.op = CELL_HOLD;
        end
    end

endmodule
`default_nettype wire
